FILE: src/mms_pkg.sv
package mms_pkg;

  localparam int CH_W      = 4;
  localparam int SMP_W     = 12;
  localparam int SUM_W     = 15;
  localparam int CLR_IDX_W = 12;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [SMP_W-1:0] smp_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                 busy;
    logic                 sum_we;
    logic [CLR_IDX_W-1:0] idx;
  } mms_clr_t;

endpackage

FILE: src/mms_if.sv
interface mms_in_if;
  import mms_pkg::*;

  logic  valid;
  logic  ready;
  chan_t channel;
  smp_t  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mms_out_if;
  import mms_pkg::*;

  logic  valid;
  logic  ready;
  chan_t channel_out;
  sum_t  window_sum;

  modport source (output valid, output channel_out, output window_sum, input ready);
  modport sink (input valid, input channel_out, input window_sum, output ready);
endinterface

FILE: src/mms_ram.sv
module mms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mms_clear.sv
module mms_clear #(
  parameter int HIST_DEPTH = 128,
  parameter int CHANNELS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  output mms_pkg::mms_clr_t  clr
);
  import mms_pkg::*;

  localparam int AW = $clog2(HIST_DEPTH);

  logic          busy_r;
  logic          busy_nxt;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_nxt;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (busy_r) begin
      idx_nxt = idx_r + AW'(1);
      if (idx_r == AW'(HIST_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign clr.busy   = busy_r;
  assign clr.sum_we = busy_r && (int'(idx_r) < CHANNELS);
  assign clr.idx    = CLR_IDX_W'(idx_r);

endmodule

FILE: src/multichannel_moving_sum.sv
// Moving sum over the last WINDOW samples of each of CHANNELS channels.
// The input channel carries a channel number and a 12-bit sample; the
// result channel carries the channel number and its new 15-bit sum.
// Both channels use a valid/ready handshake.
// An item with a channel number of CHANNELS or more is taken and dropped
// without a result and without any change of state.
// The sample history and the per-channel sums live in two memories with a
// registered read. An item reads both in the cycle it is taken; when it
// leaves the update stage, the sum is updated, both memories are written
// back and the result is loaded into the output register. Back-to-back
// writes to the same entry are forwarded, so one item per cycle is
// sustained while the receiver keeps up. A result passes the update
// stage registers and then the output register before it is offered.
// After reset, a clearing pass writes zero to every entry, during which
// in_if.ready stays low.
// When the receiver stalls, the result is held in the output register and
// one more item is held in the update stage; input then stalls too.
module multichannel_moving_sum #(
  parameter int CHANNELS = 16,
  parameter int WINDOW   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  mms_in_if.sink    in_if,
  mms_out_if.source out_if
);
  import mms_pkg::*;

  localparam int HIST_DEPTH = CHANNELS * WINDOW;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SUM_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(WINDOW);

  mms_clr_t clr;

  logic               acc;
  logic               in_range;
  logic               is_last;
  logic [HIST_AW-1:0] haddr;

  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;

  logic               s1_valid_r;
  chan_t              s1_ch_r;
  smp_t               s1_smp_r;
  logic [HIST_AW-1:0] s1_haddr_r;
  logic               s1_adv;

  logic               wr_valid_r;
  logic [HIST_AW-1:0] wr_haddr_r;
  smp_t               wr_hdata_r;
  chan_t              wr_ch_r;
  sum_t               wr_sdata_r;

  smp_t               hist_rdata;
  sum_t               sum_rdata;
  smp_t               old_smp;
  sum_t               old_sum;
  sum_t               new_sum;

  logic               out_valid_r;
  chan_t              out_ch_r;
  sum_t               out_sum_r;

  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  smp_t               hist_wdata;
  logic               sum_we;
  logic [SUM_AW-1:0]  sum_waddr;
  sum_t               sum_wdata;

  mms_clear #(
    .HIST_DEPTH (HIST_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !clr.busy && (!s1_valid_r || s1_adv);
  assign acc         = in_if.valid && in_if.ready;
  assign in_range    = int'(in_if.channel) < CHANNELS;
  assign is_last     = int'(in_if.channel) == CHANNELS - 1;
  assign haddr       = HIST_AW'(int'(in_if.channel) * WINDOW + int'(pos_r));

  always_comb begin
    pos_nxt = pos_r;
    if (acc && is_last) begin
      pos_nxt = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
    end
  end

  assign old_smp = (wr_valid_r && wr_haddr_r == s1_haddr_r) ? wr_hdata_r : hist_rdata;
  assign old_sum = (wr_valid_r && wr_ch_r == s1_ch_r) ? wr_sdata_r : sum_rdata;
  assign new_sum = old_sum - SUM_W'(old_smp) + SUM_W'(s1_smp_r);

  assign hist_we    = clr.busy || s1_adv;
  assign hist_waddr = clr.busy ? clr.idx[HIST_AW-1:0] : s1_haddr_r;
  assign hist_wdata = clr.busy ? '0 : s1_smp_r;
  assign sum_we     = clr.sum_we || s1_adv;
  assign sum_waddr  = clr.busy ? clr.idx[SUM_AW-1:0] : SUM_AW'(s1_ch_r);
  assign sum_wdata  = clr.busy ? '0 : new_sum;

  mms_ram #(
    .WIDTH (SMP_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (acc),
    .raddr (haddr),
    .rdata (hist_rdata)
  );

  mms_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (acc),
    .raddr (SUM_AW'(in_if.channel)),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (acc) begin
        s1_valid_r <= in_range;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        wr_valid_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ch_r    <= in_if.channel;
      s1_smp_r   <= in_if.sample;
      s1_haddr_r <= haddr;
    end
    if (s1_adv) begin
      wr_haddr_r <= s1_haddr_r;
      wr_hdata_r <= s1_smp_r;
      wr_ch_r    <= s1_ch_r;
      wr_sdata_r <= new_sum;
      out_ch_r   <= s1_ch_r;
      out_sum_r  <= new_sum;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.channel_out = out_ch_r;
  assign out_if.window_sum  = out_sum_r;

`ifndef SYNTH
  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr.busy |-> !out_valid_r && !s1_valid_r
  ) else $error("result pending during the clearing pass");

  a_update_lands_in_output: assert property (
    @(posedge clk) disable iff (!rst_n) rst_n && s1_adv |=> out_valid_r && out_ch_r == $past(s1_ch_r)
  ) else $error("updated sum did not reach the output register");

  a_ring_moves_on_last_channel: assert property (
    @(posedge clk) disable iff (!rst_n)
      $past(rst_n) && !$stable(pos_r) |-> $past(acc && is_last)
  ) else $error("ring position moved without an item for the last channel");

  a_write_tracks_update: assert property (
    @(posedge clk) disable iff (!rst_n)
      rst_n && s1_adv |=> wr_valid_r && wr_sdata_r == out_sum_r
  ) else $error("forwarding register out of step with the written sum");
`endif

endmodule

FILE: test/multichannel_moving_sum_test.sv
`timescale 1ns / 1ps

module multichannel_moving_sum_test;
  import mms_pkg::*;

  localparam int CHANNELS   = 16;
  localparam int WINDOW     = 8;
  localparam int IDLE_LIMIT = 1000;
  localparam int FULL_SCALE = 4095;

  typedef struct packed {
    chan_t channel;
    sum_t  total;
  } chan_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mms_in_if  in_bus ();
  mms_out_if out_bus ();

  multichannel_moving_sum #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  smp_t        sample_hist [CHANNELS][WINDOW];
  sum_t        running_sums [CHANNELS];
  int unsigned ring_slot;
  chan_sum_t   pending_sums [$];
  int          error_count;
  int          idle_cycles;
  int          gap_pct;

  initial begin
    forever #4 clk = ~clk;
  end

  // Update of the windowed sum for one sample, and the result it reports.
  function automatic chan_sum_t update_window_sum(chan_t ch, smp_t smp);
    chan_sum_t res;
    res.channel = ch;
    res.total = running_sums[ch] - sum_t'(sample_hist[ch][ring_slot]) + sum_t'(smp);
    sample_hist[ch][ring_slot] = smp;
    running_sums[ch] = res.total;
    if (ch == chan_t'(CHANNELS - 1)) begin
      ring_slot = (ring_slot + 1) % WINDOW;
    end
    return res;
  endfunction

  function automatic smp_t pick_sample();
    case ($urandom_range(9))
      0: return smp_t'(0);
      1: return smp_t'(FULL_SCALE);
      default: return smp_t'($urandom_range(FULL_SCALE));
    endcase
  endfunction

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= gap_pct);
  end

  always @(posedge clk) begin
    chan_sum_t exp_item;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready && in_bus.channel < CHANNELS) begin
        pending_sums.push_back(update_window_sum(in_bus.channel, in_bus.sample));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result, channel %0d sum %0d", $time,
                   out_bus.channel_out, out_bus.window_sum);
          error_count++;
        end else begin
          exp_item = pending_sums.pop_front();
          if (out_bus.channel_out !== exp_item.channel) begin
            $display("%0t: channel mismatch, expected %0d, actual %0d", $time,
                     exp_item.channel, out_bus.channel_out);
            error_count++;
          end
          if (out_bus.window_sum !== exp_item.total) begin
            $display("%0t: sum mismatch on channel %0d, expected %0d, actual %0d",
                     $time, exp_item.channel, exp_item.total, out_bus.window_sum);
            error_count++;
          end
        end
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_sums.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(chan_t ch, smp_t smp);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic test_extremes();
    for (int c = 0; c < CHANNELS; c++) begin
      send_sample(chan_t'(c), smp_t'(FULL_SCALE));
    end
  endtask

  // The ring slot moves on the highest channel only, in whatever order the items come.
  task automatic test_out_of_order();
    send_sample(chan_t'(CHANNELS - 1), 12'h800);
    send_sample(chan_t'(0), 12'h001);
    send_sample(chan_t'(CHANNELS - 1), 12'hAAA);
    send_sample(chan_t'(7), 12'h555);
    send_sample(chan_t'(7), 12'h000);
  endtask

  task automatic test_full_scale();
    for (int s = 0; s <= WINDOW; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        send_sample(chan_t'(c), smp_t'(FULL_SCALE));
      end
    end
    for (int s = 0; s <= WINDOW; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        send_sample(chan_t'(c), smp_t'(0));
      end
    end
  endtask

  task automatic test_random_sweeps(int sweeps);
    int kind;
    for (int s = 0; s < sweeps; s++) begin
      kind = $urandom_range(9);
      for (int c = 0; c < CHANNELS; c++) begin
        if (kind < 8) begin
          send_sample(chan_t'(c), pick_sample());
        end else if (kind == 8) begin
          if ($urandom_range(3) != 0) send_sample(chan_t'(c), pick_sample());
        end else begin
          send_sample(chan_t'($urandom_range(CHANNELS - 1)), pick_sample());
        end
      end
    end
  endtask

  task automatic test_back_to_back(int sweeps);
    gap_pct = 0;
    test_random_sweeps(sweeps);
    gap_pct = 12;
  endtask

  initial begin
    error_count    = 0;
    idle_cycles    = 0;
    gap_pct        = 12;
    ring_slot      = 0;
    in_bus.valid   = 1'b0;
    in_bus.channel = '0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      running_sums[c] = '0;
      for (int w = 0; w < WINDOW; w++) begin
        sample_hist[c][w] = '0;
      end
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_out_of_order();
    test_full_scale();
    test_random_sweeps(68);
    test_back_to_back(20);
    test_random_sweeps(20);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
